>>> rtl/core/key_value_table_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the key/value table.
// Both macros expect a clock named i_clk and an active-low reset i_rst_n in
// the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define KEY_VALUE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define KVT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key_value_table: assertion failed");

// Next-cycle implication.
`define KVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key_value_table: assertion failed");

`endif

>>> rtl/core/kvt_pkg.sv
// ---------------------------------------------------------------------------
// kvt_pkg
// Shared constants, codes and types of the key/value table.
// ---------------------------------------------------------------------------
package kvt_pkg;

    // Built table size and stored word widths.
    localparam int DEPTH      = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    // Port field widths.
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // Entry count holds 0..DEPTH, a slot index 0..DEPTH-1.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Common width for comparing the count against capacity.
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STS_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STS_DELETED   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_kvt_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
    } t_kvt_rsp;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                  cmp_en;   // latch the match flag
        logic                  set_val;  // overwrite value of the matching cell
        logic                  ins_en;   // append at slot == count
        logic                  shift_en; // slots at or above hit_idx take neighbor
        logic [IDX_W-1:0]      hit_idx;
        logic [CNT_W-1:0]      count;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_cell_ctl;

endpackage

>>> rtl/core/kvt_cell.sv
// ---------------------------------------------------------------------------
// kvt_cell
// One table slot: holds a key and value, compares against the broadcast key
// and hands its contents down to the lower neighbor on a delete.
// ---------------------------------------------------------------------------
module kvt_cell
    import kvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_W-1:0]      i_idx,
    input  t_cell_ctl             i_ctl,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic [VALUE_BITS-1:0] i_next_value,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_match,
    output logic [VALUE_BITS-1:0] o_rd_value
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_hit;
    logic                  w_live;

    assign w_live     = CNT_W'(i_idx) < i_ctl.count;
    assign o_match    = w_live && (r_key == i_ctl.key);
    assign o_key      = r_key;
    assign o_value    = r_value;
    assign o_rd_value = r_hit ? r_value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_hit <= o_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en && (i_idx >= i_ctl.hit_idx)) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end else if (i_ctl.ins_en && (CNT_W'(i_idx) == i_ctl.count)) begin
            r_key   <= i_ctl.key;
            r_value <= i_ctl.value;
        end else if (i_ctl.set_val && r_hit) begin
            r_value <= i_ctl.value;
        end
    end

endmodule

>>> rtl/core/key_value_table_top.sv
// ---------------------------------------------------------------------------
// key_value_table_top
// Insertion-ordered key/value table built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Usage:
// A command beat (put, get or delete with key and value) is taken at a rising
// edge where start is high and busy is low. Exactly one result beat follows:
// o_strobe is high for one cycle with o_rsp valid in that same cycle. The
// receiver cannot stall, so the result must be captured when it appears.
// The command passes the compare and update states, and the result is
// registered at the end of the update cycle. In the compare cycle every cell
// compares its key with the command key at once and the match is registered;
// in the update cycle the matching cell is updated, a new pair is appended,
// or cells above a deleted slot all shift down by one. busy is high only
// during the compare cycle, so a new command can be taken at the edge that
// closes the update cycle; it then sees the updated table.
// Configuration: i_cfg_we writes the capacity register from i_cfg_wdata. A
// capacity above the built depth saturates at the depth. Write it only while
// no command is in flight.
// Reset clears the entry count and sets capacity to 64; slot contents are
// left as they are, since only slots below the count are ever looked at.
// ---------------------------------------------------------------------------
module key_value_table_top
    import kvt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_kvt_req         i_req,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_strobe,
    output t_kvt_rsp         o_rsp
);

    // Control state.
    t_state              r_state;
    t_state              n_state;
    logic [CAP_W-1:0]    r_capacity;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    // Command held for the compare and update cycles.
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // Match summary latched at the end of the compare cycle.
    logic                r_found;
    logic [IDX_W-1:0]    r_hit_idx;

    // Result register.
    logic                r_strobe;
    t_kvt_rsp            r_rsp;
    t_kvt_rsp            n_rsp;

    // Decoded phase flags from the state machine.
    logic                w_accept;
    logic                w_cmp;
    logic                w_upd;

    logic                w_room;
    logic [CMP_W-1:0]    w_cap_eff;
    logic [IDX_W-1:0]    w_hit_idx;
    logic [VALUE_BITS-1:0] w_rd_or;

    t_cell_ctl             w_ctl;
    logic [KEY_BITS-1:0]   w_key   [DEPTH];
    logic [VALUE_BITS-1:0] w_value [DEPTH];
    logic [VALUE_BITS-1:0] w_rd    [DEPTH];
    logic [DEPTH-1:0]      w_match;

    // ---------------------------------------------------------------------
    // State machine: idle -> compare -> update, and straight back into
    // compare when a new command arrives at the end of the update cycle.
    // ---------------------------------------------------------------------
    assign w_accept = start && !busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = start ? ST_CMP : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy  = 1'b0;
        w_cmp = 1'b0;
        w_upd = 1'b0;
        case (r_state)
            ST_CMP: begin
                busy  = 1'b1;
                w_cmp = 1'b1;
            end
            ST_UPD: begin
                w_upd = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------
    // Capacity register and command capture.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_req.cmd;
            r_key   <= i_req.key[KEY_BITS-1:0];
            r_value <= i_req.value[VALUE_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Compare cycle: keys are unique among live slots, so at most one cell
    // matches and an OR of the gated indexes gives the hit slot.
    // ---------------------------------------------------------------------
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_hit_idx <= '0;
        end else if (w_cmp) begin
            r_found   <= |w_match;
            r_hit_idx <= w_hit_idx;
        end
    end

    // ---------------------------------------------------------------------
    // Update cycle: decide the outcome and drive the cells.
    // ---------------------------------------------------------------------
    assign w_cap_eff = (CMP_W'(r_capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                            : CMP_W'(r_capacity);
    assign w_room    = CMP_W'(r_count) < w_cap_eff;

    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_or = w_rd_or | w_rd[i];
        end
    end

    always_comb begin
        w_ctl          = '0;
        w_ctl.cmp_en   = w_cmp;
        w_ctl.hit_idx  = r_hit_idx;
        w_ctl.count    = r_count;
        w_ctl.key      = r_key;
        w_ctl.value    = r_value;
        n_count        = r_count;
        n_rsp          = '0;
        n_rsp.status   = STS_NOT_FOUND;
        case (r_cmd)
            CMD_PUT: begin
                if (r_found) begin
                    w_ctl.set_val = w_upd;
                    n_rsp.status  = STS_UPDATED;
                end else if (w_room) begin
                    w_ctl.ins_en  = w_upd;
                    n_count       = r_count + CNT_W'(1);
                    n_rsp.status  = STS_INSERTED;
                end else begin
                    n_rsp.status  = STS_FULL;
                end
            end
            CMD_GET: begin
                if (r_found) begin
                    n_rsp.status     = STS_FOUND;
                    n_rsp.read_value = VALUE_W'(w_rd_or);
                end
            end
            CMD_DEL: begin
                if (r_found) begin
                    w_ctl.shift_en = w_upd;
                    n_count        = r_count - CNT_W'(1);
                    n_rsp.status   = STS_DELETED;
                end
            end
            default: begin
                n_rsp.status = STS_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_upd;
            if (w_upd) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // ---------------------------------------------------------------------
    // Row of cells. Each cell takes its upper neighbor's contents on a
    // delete; the top cell reloads its own.
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0]   w_nk;
        logic [VALUE_BITS-1:0] w_nv;

        if (g == DEPTH - 1) begin : g_last
            assign w_nk = w_key[g];
            assign w_nv = w_value[g];
        end else begin : g_mid
            assign w_nk = w_key[g+1];
            assign w_nv = w_value[g+1];
        end

        kvt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_idx        (IDX_W'(g)),
            .i_ctl        (w_ctl),
            .i_next_key   (w_nk),
            .i_next_value (w_nv),
            .o_key        (w_key[g]),
            .o_value      (w_value[g]),
            .o_match      (w_match[g]),
            .o_rd_value   (w_rd[g])
        );
    end

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `include "key_value_table_top_assert.svh"

    `KVT_ASSERT_IMPL(a_count_range, 1'b1, r_count <= CNT_W'(DEPTH))
    `KVT_ASSERT_IMPL(a_single_match, r_state == ST_CMP, $onehot0(w_match))
    `KVT_ASSERT_NEXT(a_result_beat, r_state == ST_UPD, o_strobe)
    `KVT_ASSERT_NEXT(a_count_hold, r_state != ST_UPD, $stable(r_count))

endmodule
